@@ rtl/core/dtpc_pkg.sv @@
// Shared types, sizes and codes for the decision tree packet classifier.
// No dependencies; every other file of the block except dtpc_ram imports this package.
package dtpc_pkg;

  localparam int NODES_PER_TREE = 4096;
  localparam int TREE_COUNT_MAX = 4;
  localparam int RULE_LIMIT     = 4096;
  localparam int MAX_DEPTH      = 64;

  localparam int NODE_W    = $clog2(NODES_PER_TREE);
  localparam int TREE_W    = (TREE_COUNT_MAX > 1) ? $clog2(TREE_COUNT_MAX) : 1;
  localparam int TCNT_W    = $clog2(TREE_COUNT_MAX + 1);
  localparam int DEPTH_W   = $clog2(MAX_DEPTH);
  localparam int STORE_D   = TREE_COUNT_MAX * NODES_PER_TREE;
  localparam int ADDR_W    = $clog2(STORE_D);
  localparam int RULE_W    = 12;
  localparam int CHILD_W   = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RULE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TREE_COUNT   = 1'd1;

  localparam logic [2:0] FLD_SRC_IP   = 3'd0;
  localparam logic [2:0] FLD_DST_IP   = 3'd1;
  localparam logic [2:0] FLD_SRC_PORT = 3'd2;
  localparam logic [2:0] FLD_DST_PORT = 3'd3;
  localparam logic [2:0] FLD_PROTO    = 3'd4;

  typedef struct packed {
    logic        op;
    logic [1:0]  tree_sel;
    logic [11:0] node_addr;
    logic [2:0]  node_field;
    logic [31:0] node_threshold;
    logic [12:0] node_left;
    logic [12:0] node_right;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } dtpc_in_t;

  typedef struct packed {
    logic [11:0] best_rule;
    logic        walk_error;
  } dtpc_out_t;

  typedef struct packed {
    logic [2:0]         field;
    logic [31:0]        threshold;
    logic [CHILD_W-1:0] left;
    logic [CHILD_W-1:0] right;
  } dtpc_node_t;

  localparam int NODE_BITS = $bits(dtpc_node_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_DONE
  } dtpc_state_t;

  typedef struct packed {
    logic wr;
    logic load;
    logic rd;
    logic advance;
    logic take_leaf;
    logic flag_err;
    logic next_tree;
  } dtpc_cmd_t;

  typedef struct packed {
    logic classify;
    logic no_trees;
    logic leaf;
    logic stop;
    logic last_tree;
  } dtpc_sts_t;

endpackage

@@ rtl/core/dtpc_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module dtpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/dtpc_ctrl.sv @@
// Sequencing state machine of the classifier: accept, node fetch, evaluate, emit.
// Depends on dtpc_pkg.
module dtpc_ctrl import dtpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dtpc_sts_t sts,
  output dtpc_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  dtpc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (sts.classify) begin
            cmd.load   = 1'b1;
            state_next = sts.no_trees ? ST_DONE : ST_FETCH;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.rd     = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.leaf || sts.stop) begin
          cmd.take_leaf = sts.leaf;
          cmd.flag_err  = !sts.leaf;
          if (sts.last_tree) begin
            state_next = ST_DONE;
          end else begin
            cmd.next_tree = 1'b1;
            state_next    = ST_FETCH;
          end
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_FETCH;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/dtpc_dp.sv @@
// Datapath: configuration registers, node store, header compare and walk state.
// Depends on dtpc_pkg and dtpc_ram.
module dtpc_dp import dtpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dtpc_in_t             item,
  input  dtpc_cmd_t            cmd,
  output dtpc_sts_t            sts,
  output dtpc_out_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic [RULE_W-1:0]    rule_dflt;
  logic [2:0]           tree_count;
  logic [RULE_W-1:0]    def_sat;
  logic [TCNT_W-1:0]    trees_sat;

  logic [31:0]          src_ip;
  logic [31:0]          dst_ip;
  logic [15:0]          src_port;
  logic [15:0]          dst_port;
  logic [7:0]           protocol;
  logic [CHILD_W-1:0]   offset;
  logic [RULE_W-1:0]    best;
  logic                 err;
  logic [TCNT_W-1:0]    trees;
  logic [TREE_W-1:0]    tree;
  logic [NODE_W-1:0]    idx;
  logic [DEPTH_W-1:0]   depth;

  logic                 wr_ok;
  logic [ADDR_W-1:0]    waddr;
  logic [ADDR_W-1:0]    raddr;
  logic [NODE_BITS-1:0] wdata;
  logic [NODE_BITS-1:0] rdata;
  dtpc_node_t           node;
  dtpc_node_t           wnode;
  logic [31:0]          hval;
  logic [CHILD_W-1:0]   child;
  logic [CHILD_W-1:0]   nidx;
  logic                 range_err;
  logic                 depth_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_dflt  <= RULE_W'(4095);
      tree_count <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEFAULT_RULE: rule_dflt  <= cfg_data[RULE_W-1:0];
        REG_TREE_COUNT:   tree_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign def_sat   = (32'(rule_dflt) >= RULE_LIMIT) ? RULE_W'(RULE_LIMIT - 1) : rule_dflt;
  assign trees_sat = (32'(tree_count) > TREE_COUNT_MAX) ? TCNT_W'(TREE_COUNT_MAX)
                                                        : TCNT_W'(tree_count);

  assign wr_ok = cmd.wr && (32'(item.tree_sel) < TREE_COUNT_MAX)
                        && (32'(item.node_addr) < NODES_PER_TREE);
  assign waddr = ADDR_W'(item.tree_sel) * ADDR_W'(NODES_PER_TREE) + ADDR_W'(item.node_addr);
  assign raddr = ADDR_W'(tree) * ADDR_W'(NODES_PER_TREE) + ADDR_W'(idx);

  always_comb begin
    wnode.field     = item.node_field;
    wnode.threshold = item.node_threshold;
    wnode.left      = item.node_left;
    wnode.right     = item.node_right;
    wdata           = wnode;
  end

  dtpc_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (STORE_D)
  ) u_store (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign node = dtpc_node_t'(rdata);

  always_comb begin
    unique case (node.field)
      FLD_SRC_IP:   hval = src_ip;
      FLD_DST_IP:   hval = dst_ip;
      FLD_SRC_PORT: hval = 32'(src_port);
      FLD_DST_PORT: hval = 32'(dst_port);
      FLD_PROTO:    hval = 32'(protocol);
      default:      hval = '0;
    endcase
  end

  assign child     = (hval <= node.threshold) ? node.left : node.right;
  assign nidx      = child - offset;
  assign range_err = 32'(nidx) >= NODES_PER_TREE;
  assign depth_end = depth == DEPTH_W'(MAX_DEPTH - 1);

  assign sts.classify  = item.op == OP_CLASSIFY;
  assign sts.no_trees  = trees_sat == '0;
  assign sts.leaf      = child < offset;
  assign sts.stop      = range_err || depth_end;
  assign sts.last_tree = (TCNT_W'(tree) + TCNT_W'(1)) == trees;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_ip   <= item.src_ip;
      dst_ip   <= item.dst_ip;
      src_port <= item.src_port;
      dst_port <= item.dst_port;
      protocol <= item.protocol;
      offset   <= CHILD_W'(def_sat) + CHILD_W'(1);
      best     <= def_sat;
      err      <= 1'b0;
      trees    <= trees_sat;
      tree     <= '0;
      idx      <= '0;
      depth    <= '0;
    end else begin
      if (cmd.advance) begin
        idx   <= NODE_W'(nidx);
        depth <= depth + DEPTH_W'(1);
      end
      if (cmd.take_leaf && (child < CHILD_W'(best))) begin
        best <= RULE_W'(child);
      end
      if (cmd.flag_err) begin
        err <= 1'b1;
      end
      if (cmd.next_tree) begin
        tree  <= tree + TREE_W'(1);
        idx   <= '0;
        depth <= '0;
      end
    end
  end

  assign result.best_rule  = best;
  assign result.walk_error = err;

endmodule

@@ rtl/core/decision_tree_packet_classifier.sv @@
// Node write: no result; busy stays low. Classify: the block walks each configured tree
// (at most 4) from node 0, each walk reading at most 64 nodes, then strobes done and
// returns to idle, where the next word is taken. A zero tree count skips the walks and
// goes straight to the result. Each node costs a registered read of the node store plus
// a compare. The receiver cannot stall results. Reset is synchronous: the state and
// config registers return to their defaults, the node store keeps its contents.
module decision_tree_packet_classifier import dtpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  dtpc_in_t             item,
  output logic                 done,
  output dtpc_out_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  dtpc_cmd_t cmd;
  dtpc_sts_t sts;

  dtpc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dtpc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ rtl/core/dtpc_chk.sv @@
// Port-level checks of the classifier handshake and result timing, bound to the top.
// Depends on dtpc_pkg.
module dtpc_chk import dtpc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input dtpc_in_t  item,
  input logic      done
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_cls_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_CLASSIFY) |=> busy)
    else $error("classify word did not raise busy");

  a_wr_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_WRITE) |=> (!busy && !done))
    else $error("node write left the block busy or gave a result");

endmodule

bind decision_tree_packet_classifier dtpc_chk u_chk (.*);

@@ sim/tb_top.sv @@
// Self-checking bench for decision_tree_packet_classifier: node loads, header lookups, config.
// Needs only dtpc_pkg and the block's RTL; a local tree walker predicts every result word.
`timescale 1ns / 100ps

module tb_top;
  import dtpc_pkg::*;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  dtpc_in_t             item = '0;
  logic                 done;
  dtpc_out_t            result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  decision_tree_packet_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // live register copies, updated on config writes, and node store mirror, updated on accepted words
  logic [11:0] dflt_rule = 12'd4095;
  logic [2:0]  tree_cnt = 3'd1;
  dtpc_node_t  node_mirror [STORE_D];
  // store as it will stand once every queued word is taken
  dtpc_node_t  plan_nodes [STORE_D];
  bit          plan_valid [STORE_D];

  dtpc_in_t    pending_words [$];
  dtpc_out_t   awaited_results [$];
  dtpc_out_t   want;
  int          words_queued = 0;
  int          words_taken = 0;
  int          writes_taken = 0;
  int          lookups_taken = 0;
  int          faulty_lookups = 0;
  int          cfg_writes = 0;
  int          mismatches = 0;
  int          gap_max = 3;
  int          idle_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  function automatic dtpc_out_t lookup_rule(input dtpc_in_t pkt, input bit planned,
                                            output bit bad);
    int          trees;
    int          idx;
    int          a;
    int          t;
    int          d;
    logic [12:0] offset;
    logic [12:0] child;
    logic [11:0] best;
    logic [31:0] val;
    dtpc_node_t  nd;
    bit          hit;
    bit          fault;
    bad = 1'b0;
    fault = 1'b0;
    trees = (int'(tree_cnt) > TREE_COUNT_MAX) ? TREE_COUNT_MAX : int'(tree_cnt);
    best = (int'(dflt_rule) > RULE_LIMIT - 1) ? 12'(RULE_LIMIT - 1) : dflt_rule;
    offset = {1'b0, best} + 13'd1;
    for (t = 0; t < trees; t++) begin
      idx = 0;
      hit = 1'b0;
      for (d = 0; d < MAX_DEPTH && !hit && idx < NODES_PER_TREE; d++) begin
        a = t * NODES_PER_TREE + idx;
        if (planned && !plan_valid[a]) bad = 1'b1;
        nd = planned ? plan_nodes[a] : node_mirror[a];
        case (nd.field)
          FLD_SRC_IP:   val = pkt.src_ip;
          FLD_DST_IP:   val = pkt.dst_ip;
          FLD_SRC_PORT: val = {16'd0, pkt.src_port};
          FLD_DST_PORT: val = {16'd0, pkt.dst_port};
          FLD_PROTO:    val = {24'd0, pkt.protocol};
          default:      val = '0;
        endcase
        child = (val <= nd.threshold) ? nd.left : nd.right;
        if (child < offset) begin
          hit = 1'b1;
          if (child[11:0] < best) best = child[11:0];
        end else begin
          idx = int'(child - offset);
        end
      end
      if (!hit) fault = 1'b1;
    end
    return {best, fault};
  endfunction

  function automatic dtpc_in_t random_word();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(dtpc_in_t)-1:0];
  endfunction

  function automatic dtpc_in_t header(input logic [31:0] sip, input logic [31:0] dip,
                                      input logic [15:0] sp, input logic [15:0] dp,
                                      input logic [7:0] pr);
    dtpc_in_t p;
    p = random_word();
    p.src_ip = sip;
    p.dst_ip = dip;
    p.src_port = sp;
    p.dst_port = dp;
    p.protocol = pr;
    return p;
  endfunction

  function automatic dtpc_in_t random_header();
    dtpc_in_t p;
    p = random_word();
    case ($urandom_range(0, 7))
      0: p = header('0, '0, '0, '0, '0);
      1: p = header('1, '1, '1, '1, '1);
      default: ;
    endcase
    return p;
  endfunction

  // queue a lookup only if its walks touch loaded nodes alone
  function automatic bit offer_lookup(input dtpc_in_t pkt);
    bit        bad;
    dtpc_out_t scratch;
    pkt.op = OP_CLASSIFY;
    scratch = lookup_rule(pkt, 1'b1, bad);
    if (!bad) begin
      pending_words.push_back(pkt);
      words_queued++;
    end
    return !bad;
  endfunction

  task automatic push_node(input int t, input int a, input logic [2:0] f,
                           input logic [31:0] thr, input logic [12:0] l,
                           input logic [12:0] r);
    dtpc_in_t w;
    int       slot;
    w = random_word();
    w.op = OP_WRITE;
    w.tree_sel = 2'(t);
    w.node_addr = 12'(a);
    w.node_field = f;
    w.node_threshold = thr;
    w.node_left = l;
    w.node_right = r;
    slot = t * NODES_PER_TREE + a;
    plan_nodes[slot] = {f, thr, l, r};
    plan_valid[slot] = 1'b1;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [12:0] pick_child(input int i, input int k);
    int roll;
    int off;
    roll = $urandom_range(0, 99);
    off = int'(dflt_rule) + 1;
    if (i < k - 1 && roll < 45) return 13'(off + $urandom_range(i + 1, k - 1));
    if (roll < 48) return 13'(off + i);
    if (roll < 52 && off <= 4095)
      return 13'(off + NODES_PER_TREE + $urandom_range(0, 4095 - off));
    case (roll % 3)
      0:       return 13'd0;
      1:       return {1'b0, dflt_rule};
      default: return 13'($urandom_range(0, int'(dflt_rule)));
    endcase
  endfunction

  function automatic logic [31:0] pick_threshold(input logic [2:0] f);
    if ($urandom_range(0, 7) == 0) return $urandom;
    case (f)
      FLD_SRC_PORT, FLD_DST_PORT: return 32'($urandom_range(0, 65535));
      FLD_PROTO:                  return 32'($urandom_range(0, 255));
      default:                    return $urandom;
    endcase
  endfunction

  task automatic build_trees(input int k_max);
    int         t;
    int         i;
    int         k;
    logic [2:0] f;
    for (t = 0; t < TREE_COUNT_MAX; t++) begin
      k = $urandom_range(1, k_max);
      for (i = 0; i < k; i++) begin
        f = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        push_node(t, i, f, pick_threshold(f), pick_child(i, k), pick_child(i, k));
      end
    end
  endtask

  // hold until every queued word is taken and every result is back
  task automatic drain(input int tail);
    do @(posedge clk);
    while (words_taken != words_queued || awaited_results.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_config(input logic [11:0] rule, input logic [11:0] count_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEFAULT_RULE;
    cfg_data <= rule;
    do @(posedge clk); while (!cfg_ready);
    dflt_rule = rule;
    cfg_index <= REG_TREE_COUNT;
    cfg_data <= count_word;
    do @(posedge clk); while (!cfg_ready);
    tree_cnt = count_word[2:0];
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  // driver: hold while busy, take the word on handshake, then idle or advance
  always @(posedge clk) begin
    bit scratch;
    int gap;
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        words_taken++;
        if (item.op == OP_WRITE) begin
          node_mirror[int'(item.tree_sel) * NODES_PER_TREE + int'(item.node_addr)] =
            {item.node_field, item.node_threshold, item.node_left, item.node_right};
          writes_taken++;
        end else begin
          awaited_results.push_back(lookup_rule(item, 1'b0, scratch));
          lookups_taken++;
          if (awaited_results[$].walk_error) faulty_lookups++;
        end
      end
      gap = start ? $urandom_range(0, gap_max) : idle_left;
      if (gap > 0) begin
        idle_left <= gap - 1;
        start <= 1'b0;
      end else if (pending_words.size() != 0) begin
        item <= pending_words.pop_front();
        start <= 1'b1;
        idle_left <= 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result word with none awaited: rule %0d error %0b",
                                result.best_rule, result.walk_error));
      end else begin
        want = awaited_results.pop_front();
        if (result.best_rule !== want.best_rule)
          flag_mismatch($sformatf("best_rule %0d, predicted %0d",
                                  result.best_rule, want.best_rule));
        if (result.walk_error !== want.walk_error)
          flag_mismatch($sformatf("walk_error %0b, predicted %0b",
                                  result.walk_error, want.walk_error));
      end
    end
  end

  initial begin
    int phase;
    int n;
    int tries;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: offset 101, four hand-built trees
    set_config(12'd100, 12'd4);
    push_node(0, 0, FLD_DST_PORT, 32'd100, 13'd7, 13'd102);
    push_node(0, 1, FLD_PROTO, 32'd0, 13'd0, 13'd100);
    push_node(1, 0, 3'd5, 32'd0, 13'd3, 13'd8191);
    push_node(2, 0, FLD_SRC_IP, 32'h7FFF_FFFF, 13'd50, 13'd4197);
    push_node(3, 0, FLD_DST_IP, 32'd0, 13'd101, 13'd60);
    void'(offer_lookup(header('0, '0, '0, '0, '0)));
    void'(offer_lookup(header('1, '1, '1, '1, '1)));
    void'(offer_lookup(header(32'h7FFF_FFFF, 32'd1, 16'd5, 16'd100, 8'd9)));
    void'(offer_lookup(header(32'h8000_0000, 32'hFFFF_FFFF, 16'd0, 16'd101, 8'd0)));
    void'(offer_lookup(header($urandom, 32'd0, 16'hFFFF, 16'd101, 8'd1)));
    void'(offer_lookup(header(32'h0000_0001, 32'h8000_0000, 16'h8000, 16'd99, 8'h80)));
    drain(4);
    set_config(12'd100, 12'd0);
    void'(offer_lookup(header('1, '0, '1, '0, '1)));
    void'(offer_lookup(random_header()));
    drain(4);
    set_config(12'd100, 12'hFFF);
    void'(offer_lookup(header('0, '1, '0, '1, '0)));
    void'(offer_lookup(random_header()));

    phase = 0;
    while (words_queued < 650) begin
      drain(4);
      case (phase % 6)
        0:       n = 0;
        1:       n = 4095;
        2:       n = 4094;
        3:       n = 1;
        default: n = $urandom_range(0, 4095);
      endcase
      set_config(12'(n), {9'($urandom_range(0, 511)),
                          (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7))});
      gap_max = (phase % 4 == 3) ? 0 : 3;
      build_trees((phase % 3 == 0) ? 12 : 5);
      for (n = 0; n < 40; n++) begin
        if (n == 20 && phase % 3 == 1) drain(0);
        if ($urandom_range(0, 19) == 0) begin
          push_node($urandom_range(0, 3), $urandom_range(0, 4095), 3'($urandom_range(0, 7)),
                    $urandom, 13'($urandom), 13'($urandom));
        end else begin
          tries = 0;
          while (tries < 8 && !offer_lookup(random_header())) tries++;
        end
      end
      phase++;
    end
    drain(20);

    $display("run covered %0d node loads and %0d lookups, %0d of them with walk faults,",
             writes_taken, lookups_taken, faulty_lookups);
    $display("across %0d register writes over %0d settings", cfg_writes, phase + 3);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
